FILE: sv/ngcs_pkg.sv
`default_nettype none
package ngcs_pkg;

  localparam int MUL_W = 64;
  localparam int DIV_W = 128;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LOG2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] STATUS_OK = 3'd0;
  localparam logic [2:0] STATUS_OUTSIDE = 3'd1;
  localparam logic [2:0] STATUS_NOT_OCC = 3'd2;
  localparam logic [2:0] STATUS_SINGULAR = 3'd3;
  localparam logic [2:0] STATUS_SATURATED = 3'd4;

  // Kind of result the output register is loaded with.
  localparam logic [2:0] RES_ZERO = 3'd0;
  localparam logic [2:0] RES_OUTSIDE = 3'd1;
  localparam logic [2:0] RES_FULL = 3'd2;
  localparam logic [2:0] RES_ADD = 3'd3;
  localparam logic [2:0] RES_NOT_OCC = 3'd4;
  localparam logic [2:0] RES_SINGULAR = 3'd5;
  localparam logic [2:0] RES_OK = 3'd6;

  // Query micro-steps, run in this order on the shared multiplier and divider.
  localparam logic [3:0] STEP_XX_NS = 4'd0;
  localparam logic [3:0] STEP_XX_SS = 4'd1;
  localparam logic [3:0] STEP_XX_DIV = 4'd2;
  localparam logic [3:0] STEP_XY_NS = 4'd3;
  localparam logic [3:0] STEP_XY_SS = 4'd4;
  localparam logic [3:0] STEP_XY_DIV = 4'd5;
  localparam logic [3:0] STEP_YY_NS = 4'd6;
  localparam logic [3:0] STEP_YY_SS = 4'd7;
  localparam logic [3:0] STEP_YY_DIV = 4'd8;
  localparam logic [3:0] STEP_DET_A = 4'd9;
  localparam logic [3:0] STEP_DET_B = 4'd10;
  localparam logic [3:0] STEP_INV_XX = 4'd11;
  localparam logic [3:0] STEP_INV_XY = 4'd12;
  localparam logic [3:0] STEP_INV_YY = 4'd13;
  localparam logic [3:0] STEP_MEAN_X = 4'd14;
  localparam logic [3:0] STEP_MEAN_Y = 4'd15;
  localparam logic [3:0] STEP_LAST = STEP_MEAN_Y;

  typedef struct packed {
    logic [15:0] cnt;
    logic [35:0] sx;
    logic [35:0] sy;
    logic [54:0] sxx;
    logic [55:0] sxy;
    logic [54:0] syy;
  } ent_t;

  typedef struct packed {
    logic       load_item;
    logic       mem_write;
    logic       clear_run;
    logic       mul_start;
    logic       div_start;
    logic       latch;
    logic [3:0] step;
    logic       load_out;
    logic [2:0] res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       cnt_full;
    logic       occupied;
    logic       det_pos;
    logic       mul_done;
    logic       div_done;
    logic       clear_done;
  } stat_t;

  function automatic logic step_is_div(input logic [3:0] step);
    logic r;
    case (step) inside
      STEP_XX_DIV, STEP_XY_DIV, STEP_YY_DIV, STEP_INV_XX, STEP_INV_XY, STEP_INV_YY,
      STEP_MEAN_X, STEP_MEAN_Y: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic [DIV_W-1:0] q);
    logic [47:0] r;
    if ((&q[DIV_W-1:47]) || !(|q[DIV_W-1:47])) r = q[47:0];
    else if (q[DIV_W-1]) r = {1'b1, 47'd0};
    else r = {1'b0, {47{1'b1}}};
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ngcs_mul.sv
`default_nettype none
module ngcs_mul import ngcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p,
  output logic                      done
);
  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN = 2'd1;
  localparam logic [1:0] PH_FIX = 2'd2;

  logic [1:0] phase;
  logic [2*MUL_W-1:0] mcand;
  logic [2*MUL_W-1:0] acc;
  logic [MUL_W-1:0] mplier;
  logic [CNT_W-1:0] cnt;
  logic neg;
  logic [MUL_W-1:0] amag;
  logic [MUL_W-1:0] bmag;

  assign amag = a[MUL_W-1] ? (~a + 1'b1) : a;
  assign bmag = b[MUL_W-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            mcand <= {{MUL_W{1'b0}}, amag};
            mplier <= bmag;
            acc <= '0;
            cnt <= '0;
            neg <= a[MUL_W-1] ^ b[MUL_W-1];
            phase <= PH_RUN;
          end
        end
        PH_RUN: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_W - 1)) phase <= PH_FIX;
        end
        PH_FIX: begin
          p <= neg ? $signed(~acc + 1'b1) : $signed(acc);
          done <= 1'b1;
          phase <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/ngcs_div.sv
`default_nettype none
module ngcs_div import ngcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic [DIV_W-1:0]        den,
  output logic signed [DIV_W-1:0] q,
  output logic                    done
);
  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN = 2'd1;
  localparam logic [1:0] PH_FIX = 2'd2;

  logic [1:0] phase;
  logic [DIV_W-1:0] nq;
  logic [DIV_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic neg;
  logic [DIV_W:0] rt;
  logic [DIV_W:0] diff;
  logic ge;

  assign rt = {r, nq[DIV_W-1]};
  assign diff = rt - {1'b0, den};
  assign ge = rt >= {1'b0, den};

  // Floor quotient of a negative numerator: -q when exact, otherwise -q-1 = ~q.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            neg <= num[DIV_W-1];
            nq <= num[DIV_W-1] ? (~num + 1'b1) : num;
            r <= '0;
            cnt <= '0;
            phase <= PH_RUN;
          end
        end
        PH_RUN: begin
          r <= ge ? diff[DIV_W-1:0] : rt[DIV_W-1:0];
          nq <= {nq[DIV_W-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_W - 1)) phase <= PH_FIX;
        end
        PH_FIX: begin
          if (!neg) q <= $signed(nq);
          else if (r != '0) q <= $signed(~nq);
          else q <= $signed(~nq + 1'b1);
          done <= 1'b1;
          phase <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/ngcs_datapath.sv
`default_nettype none
module ngcs_datapath import ngcs_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int INV_FRAC = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]             op,
  input  logic signed [19:0]     point_x,
  input  logic signed [19:0]     point_y,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic [2:0]             status,
  output logic [15:0]            point_count,
  output logic signed [19:0]     mean_x,
  output logic signed [19:0]     mean_y,
  output logic [38:0]            cov_xx,
  output logic signed [39:0]     cov_xy,
  output logic [38:0]            cov_yy,
  output logic signed [47:0]     inv_xx,
  output logic signed [47:0]     inv_xy,
  output logic signed [47:0]     inv_yy
);
  localparam int NCELLS = GRID_X * GRID_Y;
  localparam int ADDR_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;

  logic signed [19:0] origin_x;
  logic signed [19:0] origin_y;
  logic [4:0] cell_log2;
  logic [15:0] min_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      cell_log2 <= 5'd8;
      min_points <= 16'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_CELL_LOG2: cell_log2 <= cfg_data[4:0];
        REG_MIN_POINTS: min_points <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Cell index of the incoming point; the shift floors toward minus infinity.
  logic signed [20:0] dx, dy, ix, iy;
  logic in_range_in;
  logic [31:0] cell_lin;
  logic [ADDR_W-1:0] addr_in;

  assign dx = {point_x[19], point_x} - {origin_x[19], origin_x};
  assign dy = {point_y[19], point_y} - {origin_y[19], origin_y};
  assign ix = dx >>> cell_log2;
  assign iy = dy >>> cell_log2;
  assign in_range_in = !ix[20] && !iy[20] && (ix < 21'(GRID_X)) && (iy < 21'(GRID_Y));
  assign cell_lin = 32'($unsigned(iy)) * 32'(GRID_X) + 32'($unsigned(ix));
  assign addr_in = cell_lin[ADDR_W-1:0];

  logic [1:0] op_r;
  logic in_range_r;
  logic [ADDR_W-1:0] addr_r;
  logic signed [39:0] pxx, pxy, pyy;
  logic signed [19:0] px_r, py_r;
  ent_t rd_ent;
  ent_t new_ent;
  ent_t mem [NCELLS];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= op;
      in_range_r <= in_range_in;
      addr_r <= addr_in;
      px_r <= point_x;
      py_r <= point_y;
      pxx <= point_x * point_x;
      pxy <= point_x * point_y;
      pyy <= point_y * point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) rd_ent <= mem[addr_in];
    if (cmd.clear_run) mem[clr_addr] <= '0;
    else if (cmd.mem_write) mem[addr_r] <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_run) begin
      if (stat.clear_done) clr_addr <= '0;
      else clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    new_ent.cnt = rd_ent.cnt + 16'd1;
    new_ent.sx = rd_ent.sx + {{16{px_r[19]}}, px_r};
    new_ent.sy = rd_ent.sy + {{16{py_r[19]}}, py_r};
    new_ent.sxx = rd_ent.sxx + {15'd0, pxx};
    new_ent.sxy = rd_ent.sxy + {{16{pxy[39]}}, pxy};
    new_ent.syy = rd_ent.syy + {15'd0, pyy};
  end

  logic [15:0] minp_eff;
  logic [31:0] nn1;
  assign minp_eff = (min_points < 16'd2) ? 16'd2 : min_points;

  always_ff @(posedge clk) begin
    nn1 <= rd_ent.cnt * (rd_ent.cnt - 16'd1);
  end

  // Query arithmetic on the shared multiplier and divider.
  logic signed [MUL_W-1:0] n64, sx64, sy64, sxx64, sxy64, syy64;
  logic signed [MUL_W-1:0] cxx, cxy, cyy;
  logic signed [2*MUL_W-1:0] t;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic mul_done;
  logic signed [DIV_W-1:0] div_num, div_q;
  logic [DIV_W-1:0] div_den;
  logic div_done;
  logic signed [DIV_W-1:0] ext_cxx, ext_cyy, ext_ncxy;
  logic signed [19:0] mean_x_r, mean_y_r;
  logic [47:0] inv_xx_r, inv_xy_r, inv_yy_r;

  assign n64 = {48'd0, rd_ent.cnt};
  assign sx64 = {{28{rd_ent.sx[35]}}, rd_ent.sx};
  assign sy64 = {{28{rd_ent.sy[35]}}, rd_ent.sy};
  assign sxx64 = {9'd0, rd_ent.sxx};
  assign sxy64 = {{8{rd_ent.sxy[55]}}, rd_ent.sxy};
  assign syy64 = {9'd0, rd_ent.syy};
  assign ext_cxx = {{MUL_W{cxx[MUL_W-1]}}, cxx};
  assign ext_cyy = {{MUL_W{cyy[MUL_W-1]}}, cyy};
  assign ext_ncxy = ~{{MUL_W{cxy[MUL_W-1]}}, cxy} + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step) inside
      STEP_XX_NS: begin mul_a = n64; mul_b = sxx64; end
      STEP_XX_SS: begin mul_a = sx64; mul_b = sx64; end
      STEP_XY_NS: begin mul_a = n64; mul_b = sxy64; end
      STEP_XY_SS: begin mul_a = sx64; mul_b = sy64; end
      STEP_YY_NS: begin mul_a = n64; mul_b = syy64; end
      STEP_YY_SS: begin mul_a = sy64; mul_b = sy64; end
      STEP_DET_A: begin mul_a = cxx; mul_b = cyy; end
      STEP_DET_B: begin mul_a = cxy; mul_b = cxy; end
      default: ;
    endcase
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.step) inside
      STEP_XX_DIV, STEP_XY_DIV, STEP_YY_DIV: begin
        div_num = t;
        div_den = {96'd0, nn1};
      end
      STEP_INV_XX: begin div_num = ext_cyy << INV_FRAC; div_den = t; end
      STEP_INV_XY: begin div_num = ext_ncxy << INV_FRAC; div_den = t; end
      STEP_INV_YY: begin div_num = ext_cxx << INV_FRAC; div_den = t; end
      STEP_MEAN_X: begin div_num = {{92{rd_ent.sx[35]}}, rd_ent.sx}; div_den = DIV_W'(n64); end
      STEP_MEAN_Y: begin div_num = {{92{rd_ent.sy[35]}}, rd_ent.sy}; div_den = DIV_W'(n64); end
      default: ;
    endcase
  end

  ngcs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  ngcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .q     (div_q),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      case (cmd.step) inside
        STEP_XX_NS, STEP_XY_NS, STEP_YY_NS, STEP_DET_A: t <= mul_p;
        STEP_XX_SS, STEP_XY_SS, STEP_YY_SS, STEP_DET_B: t <= t - mul_p;
        STEP_XX_DIV: cxx <= div_q[MUL_W-1:0];
        STEP_XY_DIV: cxy <= div_q[MUL_W-1:0];
        STEP_YY_DIV: cyy <= div_q[MUL_W-1:0];
        STEP_INV_XX: inv_xx_r <= sat48(div_q);
        STEP_INV_XY: inv_xy_r <= sat48(div_q);
        STEP_INV_YY: inv_yy_r <= sat48(div_q);
        STEP_MEAN_X: mean_x_r <= div_q[19:0];
        STEP_MEAN_Y: mean_y_r <= div_q[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.op = op_r;
    stat.in_range = in_range_r;
    stat.cnt_full = rd_ent.cnt == 16'hFFFF;
    stat.occupied = rd_ent.cnt >= minp_eff;
    stat.det_pos = !t[2*MUL_W-1] && (t != '0);
    stat.mul_done = mul_done;
    stat.div_done = div_done;
    stat.clear_done = clr_addr == ADDR_W'(NCELLS - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= STATUS_OK;
      point_count <= '0;
      mean_x <= '0;
      mean_y <= '0;
      cov_xx <= '0;
      cov_xy <= '0;
      cov_yy <= '0;
      inv_xx <= '0;
      inv_xy <= '0;
      inv_yy <= '0;
      case (cmd.res)
        RES_OUTSIDE: status <= STATUS_OUTSIDE;
        RES_FULL: begin
          status <= STATUS_SATURATED;
          point_count <= rd_ent.cnt;
        end
        RES_ADD: point_count <= new_ent.cnt;
        RES_NOT_OCC: begin
          status <= STATUS_NOT_OCC;
          point_count <= rd_ent.cnt;
        end
        RES_SINGULAR: begin
          status <= STATUS_SINGULAR;
          point_count <= rd_ent.cnt;
        end
        RES_OK: begin
          point_count <= rd_ent.cnt;
          mean_x <= mean_x_r;
          mean_y <= mean_y_r;
          cov_xx <= cxx[38:0];
          cov_xy <= cxy[39:0];
          cov_yy <= cyy[38:0];
          inv_xx <= inv_xx_r;
          inv_xy <= inv_xy_r;
          inv_yy <= inv_yy_r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/ngcs_ctrl.sv
`default_nettype none
module ngcs_ctrl import ngcs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  output logic  result_valid,
  input  logic  result_stall,
  input  stat_t stat,
  output cmd_t  cmd
);
  localparam logic [2:0] ST_RCLR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_CLR = 3'd3;
  localparam logic [2:0] ST_MSTART = 3'd4;
  localparam logic [2:0] ST_MWAIT = 3'd5;
  localparam logic [2:0] ST_CHKDET = 3'd6;
  localparam logic [2:0] ST_FIN = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] step, step_next;
  logic [2:0] res_hold, res_hold_next;
  logic out_free;

  assign out_free = !result_valid || !result_stall;
  assign item_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    step_next = step;
    res_hold_next = res_hold;
    cmd = '0;
    cmd.step = step;
    unique case (state)
      ST_RCLR: begin
        cmd.clear_run = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.op == OP_CLEAR) state_next = ST_CLR;
        else if (stat.op == OP_QUERY && stat.in_range && stat.occupied) begin
          step_next = STEP_XX_NS;
          state_next = ST_MSTART;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
          if (stat.op == OP_ADD) begin
            if (!stat.in_range) cmd.res = RES_OUTSIDE;
            else if (stat.cnt_full) cmd.res = RES_FULL;
            else begin
              cmd.res = RES_ADD;
              cmd.mem_write = 1'b1;
            end
          end else if (stat.op == OP_QUERY) begin
            cmd.res = stat.in_range ? RES_NOT_OCC : RES_OUTSIDE;
          end else cmd.res = RES_ZERO;
        end
      end
      ST_CLR: begin
        cmd.clear_run = 1'b1;
        if (stat.clear_done) begin
          res_hold_next = RES_ZERO;
          state_next = ST_FIN;
        end
      end
      ST_MSTART: begin
        if (step_is_div(step)) cmd.div_start = 1'b1;
        else cmd.mul_start = 1'b1;
        state_next = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat.mul_done || stat.div_done) begin
          cmd.latch = 1'b1;
          if (step == STEP_DET_B) state_next = ST_CHKDET;
          else if (step == STEP_LAST) begin
            res_hold_next = RES_OK;
            state_next = ST_FIN;
          end else begin
            step_next = step + 4'd1;
            state_next = ST_MSTART;
          end
        end
      end
      ST_CHKDET: begin
        if (stat.det_pos) begin
          step_next = step + 4'd1;
          state_next = ST_MSTART;
        end else begin
          res_hold_next = RES_SINGULAR;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.res = res_hold;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RCLR;
      step <= STEP_XX_NS;
      res_hold <= RES_ZERO;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      res_hold <= res_hold_next;
      if (cmd.load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiplier and divider started together");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !cmd.load_out)
    else $error("pending result overwritten");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    (stat.mul_done || stat.div_done) |-> (state == ST_MWAIT))
    else $error("arithmetic unit finished outside a query step");
endmodule
`default_nettype wire

FILE: sv/ndt_grid_cell_statistics.sv
// Normal-distribution cell grid for 2D scan matching.
// Input channel (item_valid/item_stall): op, point_x, point_y. A transaction
// completes at a clock edge with valid high and stall low. op 0 adds a point to
// its cell, op 1 queries the cell holding the point, op 2 clears all cells.
// Output channel (result_valid/result_stall): one result transaction per item.
// Configuration: cfg_write with cfg_index and cfg_data, written only when idle
// by the user; the block itself does not enforce this. An add, an unused op or a
// query that needs no arithmetic loads its result into the output register once
// that register is free, and the next item waits for the cell store read and
// write-back of the last. A query of an occupied cell runs 8 multiplies
// (shift-add) and up to 8 floor divisions (one quotient bit a cycle) on shared
// units. A clear sweeps the store one cell a cycle. After reset the same clearing
// pass runs with item_stall high; configuration writes are taken throughout.
// One item is processed at a time. A result waiting under result_stall is held
// in the output register; the next item is still accepted and runs until it
// needs the output register.
`default_nettype none
module ndt_grid_cell_statistics import ngcs_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int INV_FRAC = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            op,
  input  logic signed [19:0]    point_x,
  input  logic signed [19:0]    point_y,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [2:0]            status,
  output logic [15:0]           point_count,
  output logic signed [19:0]    mean_x,
  output logic signed [19:0]    mean_y,
  output logic [38:0]           cov_xx,
  output logic signed [39:0]    cov_xy,
  output logic [38:0]           cov_yy,
  output logic signed [47:0]    inv_xx,
  output logic signed [47:0]    inv_xy,
  output logic signed [47:0]    inv_yy
);
  cmd_t cmd;
  stat_t stat;

  ngcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  ngcs_datapath #(
    .GRID_X   (GRID_X),
    .GRID_Y   (GRID_Y),
    .INV_FRAC (INV_FRAC)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .point_x     (point_x),
    .point_y     (point_y),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .point_count (point_count),
    .mean_x      (mean_x),
    .mean_y      (mean_y),
    .cov_xx      (cov_xx),
    .cov_xy      (cov_xy),
    .cov_yy      (cov_yy),
    .inv_xx      (inv_xx),
    .inv_xy      (inv_xy),
    .inv_yy      (inv_yy)
  );
endmodule
`default_nettype wire

FILE: bench/cell_stats_checker.sv
module cell_stats_checker import ngcs_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int INV_FRAC = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  logic [1:0]            op,
  input  logic signed [19:0]    point_x,
  input  logic signed [19:0]    point_y,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [2:0]            status,
  input  logic [15:0]           point_count,
  input  logic signed [19:0]    mean_x,
  input  logic signed [19:0]    mean_y,
  input  logic [38:0]           cov_xx,
  input  logic signed [39:0]    cov_xy,
  input  logic [38:0]           cov_yy,
  input  logic signed [47:0]    inv_xx,
  input  logic signed [47:0]    inv_xy,
  input  logic signed [47:0]    inv_yy,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELLS = GRID_X * GRID_Y;
  localparam int QDEPTH = 8;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [2:0]         st;
    logic [15:0]        cnt;
    logic signed [19:0] mx;
    logic signed [19:0] my;
    logic [38:0]        cxx;
    logic signed [39:0] cxy;
    logic [38:0]        cyy;
    logic signed [47:0] ixx;
    logic signed [47:0] ixy;
    logic signed [47:0] iyy;
  } cell_stats_t;

  logic signed [19:0] org_x, org_y;
  logic [4:0]         cell_shift;
  logic [15:0]        min_pts;

  logic [15:0] n_pts [NCELLS];
  longint      s_x [NCELLS];
  longint      s_y [NCELLS];
  longint      s_xx [NCELLS];
  longint      s_xy [NCELLS];
  longint      s_yy [NCELLS];

  cell_stats_t awaited_stats [QDEPTH];
  int          rd_ptr;
  int          wr_ptr;

  function automatic void wipe_cells();
    for (int i = 0; i < NCELLS; i++) begin
      n_pts[i] = '0;
      s_x[i] = 0;
      s_y[i] = 0;
      s_xx[i] = 0;
      s_xy[i] = 0;
      s_yy[i] = 0;
    end
  endfunction

  function automatic wide_t floor_quot(wide_t num, wide_t den);
    wide_t q;
    q = num / den;
    if (num % den != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic wide_t sample_cov(longint n, longint sa, longint sb, longint sab);
    wide_t wn, wa, wb, wab;
    wn = n;
    wa = sa;
    wb = sb;
    wab = sab;
    return floor_quot(wn * wab - wa * wb, wn * (wn - 1));
  endfunction

  function automatic logic signed [47:0] clip48(wide_t q);
    wide_t top, bot;
    top = (wide_t'(1) <<< 47) - 1;
    bot = -(wide_t'(1) <<< 47);
    if (q > top) return top[47:0];
    if (q < bot) return bot[47:0];
    return q[47:0];
  endfunction

  function automatic cell_stats_t cell_stats_for(logic [1:0] o, logic signed [19:0] px,
                                                 logic signed [19:0] py);
    cell_stats_t r;
    longint ix, iy, n, minp, vx, vy;
    int c;
    wide_t cxx, cxy, cyy, det, m;
    r = '0;
    vx = px;
    vy = py;
    if (o == OP_CLEAR) begin
      wipe_cells();
    end else if (o == OP_ADD || o == OP_QUERY) begin
      ix = (vx - longint'(org_x)) >>> cell_shift;
      iy = (vy - longint'(org_y)) >>> cell_shift;
      if (ix < 0 || ix >= GRID_X || iy < 0 || iy >= GRID_Y) begin
        r.st = STATUS_OUTSIDE;
      end else begin
        c = int'(iy) * GRID_X + int'(ix);
        if (o == OP_ADD) begin
          if (n_pts[c] == 16'hFFFF) begin
            r.st = STATUS_SATURATED;
          end else begin
            n_pts[c] = n_pts[c] + 1;
            s_x[c] += vx;
            s_y[c] += vy;
            s_xx[c] += vx * vx;
            s_xy[c] += vx * vy;
            s_yy[c] += vy * vy;
          end
          r.cnt = n_pts[c];
        end else begin
          n = n_pts[c];
          minp = (min_pts < 2) ? 2 : min_pts;
          r.cnt = n_pts[c];
          if (n < minp) begin
            r.st = STATUS_NOT_OCC;
          end else begin
            cxx = sample_cov(n, s_x[c], s_x[c], s_xx[c]);
            cxy = sample_cov(n, s_x[c], s_y[c], s_xy[c]);
            cyy = sample_cov(n, s_y[c], s_y[c], s_yy[c]);
            det = cxx * cyy - cxy * cxy;
            if (det <= 0) begin
              r.st = STATUS_SINGULAR;
            end else begin
              r.st = STATUS_OK;
              m = floor_quot(wide_t'(s_x[c]), wide_t'(n));
              r.mx = m[19:0];
              m = floor_quot(wide_t'(s_y[c]), wide_t'(n));
              r.my = m[19:0];
              r.cxx = cxx[38:0];
              r.cxy = cxy[39:0];
              r.cyy = cyy[38:0];
              r.ixx = clip48(floor_quot(cyy <<< INV_FRAC, det));
              r.ixy = clip48(floor_quot((-cxy) <<< INV_FRAC, det));
              r.iyy = clip48(floor_quot(cxx <<< INV_FRAC, det));
            end
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cell_stats_t got, want;
    if (rst) begin
      org_x = '0;
      org_y = '0;
      cell_shift = 5'd8;
      min_pts = 16'd3;
      wipe_cells();
      rd_ptr = 0;
      wr_ptr = 0;
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ORIGIN_X:   org_x = cfg_data;
          REG_ORIGIN_Y:   org_y = cfg_data;
          REG_CELL_LOG2:  cell_shift = cfg_data[4:0];
          REG_MIN_POINTS: min_pts = cfg_data[15:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        got = '{status, point_count, mean_x, mean_y, cov_xx, cov_xy, cov_yy,
                inv_xx, inv_xy, inv_yy};
        if (wr_ptr == rd_ptr) begin
          errors++;
          if (errors <= 10) $display("result transaction with nothing outstanding");
        end else begin
          want = awaited_stats[rd_ptr % QDEPTH];
          rd_ptr++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: st=%0d n=%0d mean=%0d,%0d cov=%0d,%0d,%0d inv=%0d,%0d,%0d",
                       want.st, want.cnt, want.mx, want.my, want.cxx, want.cxy, want.cyy,
                       want.ixx, want.ixy, want.iyy);
              $display("         got: st=%0d n=%0d mean=%0d,%0d cov=%0d,%0d,%0d inv=%0d,%0d,%0d",
                       got.st, got.cnt, got.mx, got.my, got.cxx, got.cxy, got.cyy,
                       got.ixx, got.ixy, got.iyy);
            end
          end
        end
      end
      if (item_valid && !item_stall) begin
        want = cell_stats_for(op, point_x, point_y);
        if (wr_ptr - rd_ptr >= QDEPTH) begin
          errors++;
          if (errors <= 10) $display("too many transactions outstanding");
        end else begin
          awaited_stats[wr_ptr % QDEPTH] = want;
          wr_ptr++;
        end
      end
      pending = wr_ptr - rd_ptr;
    end
  end

endmodule

FILE: bench/testbench.sv
module testbench import ngcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE = 4300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] op = OP_ADD;
  logic signed [19:0] point_x = '0;
  logic signed [19:0] point_y = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [2:0] status;
  logic [15:0] point_count;
  logic signed [19:0] mean_x, mean_y;
  logic [38:0] cov_xx, cov_yy;
  logic signed [39:0] cov_xy;
  logic signed [47:0] inv_xx, inv_xy, inv_yy;
  int errors, pending;
  int idle_cycles = 0;
  int cur_ox, cur_oy, cur_shift;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ndt_grid_cell_statistics dut (.*);
  cell_stats_checker chk (.*);

  // Receiver alternates between stalled and free stretches of random length.
  initial begin
    int hold;
    bit stalled;
    hold = 0;
    stalled = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        stalled = !stalled && ($urandom_range(0, 3) != 0);
        if (stalled) hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 3);
        else hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 6);
        result_stall <= stalled;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic send(input logic [1:0] o, input logic signed [19:0] x,
                      input logic signed [19:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    point_x <= x;
    point_y <= y;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Lets every outstanding transaction finish, including a clear sweep.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input int ox, input int oy, input int sh, input int mp);
    drain();
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_CELL_LOG2, CFG_DATA_W'(sh));
    write_reg(REG_MIN_POINTS, CFG_DATA_W'(mp));
    cur_ox = ox;
    cur_oy = oy;
    cur_shift = sh;
  endtask

  function automatic logic signed [19:0] point_in(input int org, input int idx);
    longint v;
    v = longint'(org) + (longint'(idx) <<< cur_shift) + $urandom_range(0, (1 << cur_shift) - 1);
    return v[19:0];
  endfunction

  // Mostly adds and queries aimed at a few busy cells, with some noise.
  task automatic random_traffic(input int count);
    int hx[4], hy[4];
    int r, k;
    for (int i = 0; i < 4; i++) begin
      hx[i] = $urandom_range(0, 63);
      hy[i] = $urandom_range(0, 63);
    end
    repeat (count) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 3);
      if (r < 10) begin
        send(2'($urandom_range(0, 3)), 20'($urandom), 20'($urandom));
      end else if (r < 11) begin
        send(OP_CLEAR, 20'($urandom), 20'($urandom));
      end else if (r < 13) begin
        hx[k] = int'($urandom_range(0, 65)) - 1;
        hy[k] = ($urandom_range(0, 1) == 0) ? 63 : $urandom_range(0, 63);
        send(OP_ADD, point_in(cur_ox, hx[k]), point_in(cur_oy, hy[k]));
      end else if (r < 75) begin
        send(OP_ADD, point_in(cur_ox, hx[k]), point_in(cur_oy, hy[k]));
      end else begin
        send(OP_QUERY, point_in(cur_ox, hx[k]), point_in(cur_oy, hy[k]));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    configure(0, 0, 8, 3);

    send(OP_ADD, -20'sd524288, -20'sd524288);
    send(OP_ADD, 20'sd524287, 20'sd524287);
    send(OP_ADD, -20'sd1, 20'sd0);
    send(OP_QUERY, 20'sd16384, 20'sd0);
    send(OP_QUERY, 20'sd0, 20'sd0);
    repeat (3) send(OP_ADD, 20'sd5, 20'sd7);
    send(OP_QUERY, 20'sd0, 20'sd0);
    send(OP_ADD, 20'sd300, 20'sd260);
    send(OP_ADD, 20'sd400, 20'sd500);
    send(OP_ADD, 20'sd260, 20'sd450);
    send(OP_ADD, 20'sd511, 20'sd511);
    send(OP_QUERY, 20'sd256, 20'sd256);
    send(OP_ADD, 20'sd16130, 20'sd16130);
    send(OP_ADD, 20'sd16200, 20'sd16200);
    send(OP_ADD, 20'sd16383, 20'sd16383);
    send(OP_QUERY, 20'sd16383, 20'sd16256);
    send(2'd3, 20'sd300, 20'sd300);
    send(OP_CLEAR, 20'sd0, 20'sd0);
    send(OP_QUERY, 20'sd300, 20'sd300);
    // Anticorrelated cloud gives a negative cross term.
    send(OP_ADD, 20'sd260, 20'sd500);
    send(OP_ADD, 20'sd500, 20'sd260);
    send(OP_ADD, 20'sd380, 20'sd390);
    send(OP_ADD, 20'sd300, 20'sd470);
    send(OP_QUERY, 20'sd400, 20'sd400);

    // Wide cells (shift 19): two columns, only the top row of y lies inside.
    configure(-524288, 524287, 19, 2);
    send(OP_ADD, -20'sd524288, 20'sd524287);
    send(OP_ADD, 20'sd524287, 20'sd524287);
    send(OP_ADD, 20'sd0, 20'sd0);
    send(OP_ADD, -20'sd1000, 20'sd524287);
    send(OP_QUERY, -20'sd3, 20'sd524287);
    random_traffic(60);

    // Cell size beyond the coordinate range.
    configure(0, 0, 31, 65535);
    send(OP_ADD, 20'sd5, 20'sd5);
    send(OP_ADD, -20'sd1, -20'sd1);
    send(OP_QUERY, 20'sd524287, 20'sd9);
    random_traffic(40);

    configure(-32, -32, 0, 2);
    random_traffic(300);
    configure(0, 0, 1, 1);
    random_traffic(250);

    repeat (4) begin
      configure(int'($urandom_range(0, 40000)) - 20000, int'($urandom_range(0, 40000)) - 20000,
                $urandom_range(2, 9), $urandom_range(0, 6));
      random_traffic(280);
    end

    configure(0, 0, 10, 65535);
    send(OP_ADD, 20'sd1023, 20'sd0);
    send(OP_QUERY, 20'sd0, 20'sd0);
    configure(0, 0, 10, 2);
    send(OP_QUERY, 20'sd512, 20'sd512);
    send(OP_CLEAR, 20'sd0, 20'sd0);
    send(OP_QUERY, 20'sd512, 20'sd512);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
